[src/tmfs_pkg.sv]
// ----------------------------------------------------------------------------
// tmfs_pkg
// Shared types and constants for the triangle metrics unit.
// ----------------------------------------------------------------------------
package tmfs_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int SIDE_BITS_DEF = 24;
  localparam int FIELD_W       = 24;
  localparam int VALUE_W       = 40;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONPOS = 2'd1,
    ST_NOTRI  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    Q_PERIM, Q_HALF, Q_AREA,
    Q_HT_A, Q_HT_B, Q_HT_C,
    Q_MED_A, Q_MED_B, Q_MED_C,
    Q_BIS_A, Q_BIS_B, Q_BIS_C
  } qty_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_PREP, BK_MUL_LOAD, BK_MUL_STEP, BK_SQUARE, BK_SQRT, BK_DIV, BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] side_a;
    logic signed [FIELD_W-1:0] side_b;
    logic signed [FIELD_W-1:0] side_c;
  } req_t;

  typedef struct packed {
    qty_t               quantity;
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic               last;
  } rsp_t;

endpackage

[src/triangle_metrics_from_sides_unit.sv]
// ----------------------------------------------------------------------------
// triangle_metrics_from_sides_unit
// Perimeter, area, heights, medians and bisectors from three side lengths.
// ----------------------------------------------------------------------------
// a rejected triple gives its one result; a valid triple gives all twelve results
//   in turn, and the sequencer takes no new triple before the last one is through
// the one-bit-per-cycle square root and divider set the pace per triple;
//   a two-entry queue takes triples meanwhile
// reset: rst synchronous, clears queue, sequencer and output valid
module triangle_metrics_from_sides_unit #(
  parameter int SIDE_BITS = tmfs_pkg::SIDE_BITS_DEF,
  parameter int FRAC_BITS = tmfs_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  tmfs_pkg::req_t req,
  input  logic           req_valid,
  output logic           req_stall,
  output tmfs_pkg::rsp_t rsp,
  output logic           rsp_valid,
  input  logic           rsp_stall
);
  import tmfs_pkg::*;

  localparam int ENTRY_W = 3 * SIDE_BITS + 2;

  logic               push, pop, q_full, q_empty;
  logic [ENTRY_W-1:0] push_data, pop_data;

  tmfs_front #(.SIDE_BITS(SIDE_BITS)) u_front (
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  tmfs_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  tmfs_back #(.SIDE_BITS(SIDE_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule

[src/tmfs_front.sv]
// ----------------------------------------------------------------------------
// tmfs_front
// Accepts side triples, checks sign and triangle inequality, queues them.
// ----------------------------------------------------------------------------
module tmfs_front #(
  parameter int SIDE_BITS = tmfs_pkg::SIDE_BITS_DEF
) (
  input  tmfs_pkg::req_t          req,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic                    q_full,
  output logic                    push,
  output logic [3*SIDE_BITS+1:0]  push_data
);
  import tmfs_pkg::*;

  localparam int S = SIDE_BITS;
  localparam int C = S + 1;

  logic signed [S-1:0] sa, sb, sc;
  logic [C-1:0]        wa, wb, wc;
  logic                nonpos, tri_ok;
  status_t             status;

  // low SIDE_BITS bits of each field, as a signed value
  assign sa = S'(req.side_a);
  assign sb = S'(req.side_b);
  assign sc = S'(req.side_c);

  assign wa = C'($unsigned(sa));
  assign wb = C'($unsigned(sb));
  assign wc = C'($unsigned(sc));

  assign nonpos = sa[S-1] || (sa == '0) || sb[S-1] || (sb == '0) ||
                  sc[S-1] || (sc == '0);
  assign tri_ok = (wa + wb > wc) && (wa + wc > wb) && (wb + wc > wa);

  always_comb begin
    if (nonpos) begin
      status = ST_NONPOS;
    end else if (!tri_ok) begin
      status = ST_NOTRI;
    end else begin
      status = ST_OK;
    end
  end

  assign req_stall = q_full;
  assign push      = req_valid && !q_full;
  assign push_data = {$unsigned(sa), $unsigned(sb), $unsigned(sc), status};

endmodule

[src/tmfs_queue.sv]
// ----------------------------------------------------------------------------
// tmfs_queue
// Small register queue between the classifier and the compute sequencer.
// ----------------------------------------------------------------------------
module tmfs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tmfs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import tmfs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/tmfs_back.sv]
// ----------------------------------------------------------------------------
// tmfs_back
// Sequencer that computes the twelve metrics with a chunked multiplier,
// a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
module tmfs_back #(
  parameter int SIDE_BITS = tmfs_pkg::SIDE_BITS_DEF,
  parameter int FRAC_BITS = tmfs_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  logic [3*SIDE_BITS+1:0] q_data,
  output logic                   q_pop,
  output tmfs_pkg::rsp_t         rsp,
  output logic                   rsp_valid,
  input  logic                   rsp_stall
);
  import tmfs_pkg::*;

  localparam int S     = SIDE_BITS;
  localparam int C     = S + 1;
  localparam int W     = 4 * C;
  localparam int H     = 2 * C;
  localparam int CNT_W = $clog2(H + 1);

  back_state_t state, state_next;
  qty_t        k;
  status_t     st;
  logic [S-1:0] ua, ub, uc;
  logic [H-1:0] hroot, root, dq;
  logic [H:0]   rem;
  logic [W-1:0] acc;
  logic [3*C-1:0] mcand;
  logic [C-1:0] mplier, f1, f2, f3, dr, dd;
  logic [1:0]   fi, mch;
  logic [CNT_W-1:0] cnt;
  logic [VALUE_W-1:0] val;

  logic [S-1:0] x, y, z, sq_op;
  logic [C-1:0] per, yz, two_x;
  logic [C-1:0] g0, g1, g2, g3;
  logic [2*S-1:0] sq;
  logic [H+1:0] rem2, trial, rem_n;
  logic [H-1:0] root_n, dq_n;
  logic         sq_ge, dv_ge, emit_go, iter_done;
  logic [C:0]   r2;
  logic [C-1:0] dr_n;

  // operand roles for the per-side quantities
  always_comb begin
    case (k)
      Q_HT_B, Q_MED_B, Q_BIS_B: begin
        x = ub; y = ua; z = uc;
      end
      Q_HT_C, Q_MED_C, Q_BIS_C: begin
        x = uc; y = ua; z = ub;
      end
      default: begin
        x = ua; y = ub; z = uc;
      end
    endcase
  end

  assign per   = C'(ua) + C'(ub) + C'(uc);
  assign yz    = C'(y) + C'(z);
  assign two_x = C'(x) << 1;

  // four factors: heron terms for the area, else bisector terms
  always_comb begin
    if (k == Q_AREA) begin
      g0 = per;
      g1 = C'(ub) + C'(uc) - C'(ua);
      g2 = C'(ua) + C'(uc) - C'(ub);
      g3 = C'(ua) + C'(ub) - C'(uc);
    end else begin
      g0 = C'(y);
      g1 = C'(z);
      g2 = C'(x) + C'(y) + C'(z);
      g3 = C'(y) + C'(z) - C'(x);
    end
  end

  always_comb begin
    case (mch)
      2'd0:    sq_op = x;
      2'd1:    sq_op = y;
      default: sq_op = z;
    endcase
  end
  assign sq = (2*S)'(sq_op) * (2*S)'(sq_op);

  // one root bit per cycle
  assign rem2   = {rem[H-1:0], acc[W-1:W-2]};
  assign trial  = {root, 2'b01};
  assign sq_ge  = (rem2 >= trial);
  assign rem_n  = sq_ge ? rem2 - trial : rem2;
  assign root_n = {root[H-2:0], sq_ge};

  // one quotient bit per cycle
  assign r2    = {dr, dq[H-1]};
  assign dv_ge = (r2 >= {1'b0, dd});
  assign dr_n  = dv_ge ? C'(r2 - {1'b0, dd}) : C'(r2);
  assign dq_n  = {dq[H-2:0], dv_ge};

  assign iter_done = (cnt == CNT_W'(H - 1));
  assign emit_go   = (state == BK_EMIT) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_PREP;
        end
      end
      BK_PREP: begin
        if (st != ST_OK) begin
          state_next = BK_EMIT;
        end else begin
          case (k)
            Q_AREA, Q_BIS_A, Q_BIS_B, Q_BIS_C: state_next = BK_MUL_LOAD;
            Q_HT_A, Q_HT_B, Q_HT_C:             state_next = BK_DIV;
            Q_MED_A, Q_MED_B, Q_MED_C:          state_next = BK_SQUARE;
            default:                            state_next = BK_EMIT;
          endcase
        end
      end
      BK_MUL_LOAD: state_next = BK_MUL_STEP;
      BK_MUL_STEP: begin
        if (mch == 2'd2) begin
          state_next = (fi == 2'd2) ? BK_SQRT : BK_MUL_LOAD;
        end
      end
      BK_SQUARE: begin
        if (mch == 2'd2) begin
          state_next = BK_SQRT;
        end
      end
      BK_SQRT: begin
        if (iter_done) begin
          case (k)
            Q_BIS_A, Q_BIS_B, Q_BIS_C: state_next = BK_DIV;
            default:                   state_next = BK_EMIT;
          endcase
        end
      end
      BK_DIV: begin
        if (iter_done) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (emit_go) begin
          state_next = (st != ST_OK || k == Q_BIS_C) ? BK_IDLE : BK_PREP;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          ua <= q_data[3*S+1 -: S];
          ub <= q_data[2*S+1 -: S];
          uc <= q_data[S+1 -: S];
          st <= status_t'(q_data[1:0]);
          k  <= Q_PERIM;
        end
      end
      BK_PREP: begin
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        mch  <= '0;
        fi   <= '0;
        acc  <= W'(g0);
        f1   <= g1;
        f2   <= g2;
        f3   <= g3;
        dq   <= hroot;
        dr   <= '0;
        dd   <= two_x;
        if (st != ST_OK) begin
          val <= '0;
        end else if (k == Q_HALF) begin
          val <= VALUE_W'(per >> 1);
        end else begin
          val <= VALUE_W'(per);
        end
      end
      BK_MUL_LOAD: begin
        mcand  <= acc[3*C-1:0];
        acc    <= '0;
        mplier <= f1;
        f1     <= f2;
        f2     <= f3;
        mch    <= '0;
      end
      BK_MUL_STEP: begin
        // most significant chunk first
        acc   <= (acc << C) + W'(mcand[3*C-1 -: C] * mplier);
        mcand <= mcand << C;
        mch   <= mch + 1'b1;
        if (mch == 2'd2) begin
          fi <= fi + 1'b1;
        end
      end
      BK_SQUARE: begin
        // 2y^2 + 2z^2 - x^2, wrapping
        if (mch == 2'd0) begin
          acc <= W'(0) - W'(sq);
        end else begin
          acc <= acc + (W'(sq) << 1);
        end
        mch <= mch + 1'b1;
      end
      BK_SQRT: begin
        rem  <= (H+1)'(rem_n);
        root <= root_n;
        acc  <= acc << 2;
        cnt  <= iter_done ? '0 : cnt + 1'b1;
        if (iter_done) begin
          dq  <= root_n;
          dr  <= '0;
          dd  <= yz;
          if (k == Q_AREA) begin
            hroot <= root_n;
            val   <= VALUE_W'(root_n >> (FRAC_BITS + 2));
          end else begin
            val <= VALUE_W'(root_n >> 1);
          end
        end
      end
      BK_DIV: begin
        dq  <= dq_n;
        dr  <= dr_n;
        cnt <= cnt + 1'b1;
        if (iter_done) begin
          val <= VALUE_W'(dq_n);
        end
      end
      BK_EMIT: begin
        if (emit_go) begin
          k <= qty_t'(k + 4'd1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      rsp.quantity <= (st != ST_OK) ? Q_PERIM : k;
      rsp.value    <= val;
      rsp.status   <= st;
      rsp.last     <= (st != ST_OK) || (k == Q_BIS_C);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.last && rsp.value == '0)
    else $error("error result must be a single zero item");

  a_last_bis: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_OK |-> rsp.last == (rsp.quantity == Q_BIS_C))
    else $error("last flag out of step with quantity");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == BK_PREP && k == Q_PERIM)
    else $error("new triple must start at perimeter");

endmodule

[test/triangle_metrics_from_sides_unit_test.sv]
// ----------------------------------------------------------------------------
// triangle_metrics_from_sides_unit_test
// Sends side triples to the triangle metrics unit under random sender gaps
// and receiver stalls. Each result is checked against a local exact-integer
// model of the perimeter, area, heights, medians and bisectors.
// ----------------------------------------------------------------------------
module triangle_metrics_from_sides_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tmfs_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int SIDE_MAX = 8388607;
  localparam int IDLE_LIMIT = 6000;
  localparam int RANDOM_ITEMS = 385;

  logic clk = 1'b0;
  logic rst;
  req_t req;
  logic req_valid;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall;

  rsp_t metric_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int valid_triangles = 0;
  int rejects = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int cycle_count = 0;

  triangle_metrics_from_sides_unit u_dut (
    .clk(clk), .rst(rst),
    .req(req), .req_valid(req_valid), .req_stall(req_stall),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [127:0] int_sqrt(logic [127:0] x);
    logic [127:0] root;
    logic [127:0] bitv;
    root = '0;
    bitv = 128'd1 << 126;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [VALUE_W-1:0] median_to(logic [127:0] x, logic [127:0] y,
                                                   logic [127:0] z);
    logic [127:0] radicand;
    radicand = 2 * y * y + 2 * z * z - x * x;
    return VALUE_W'(int_sqrt(radicand) / 2);
  endfunction

  function automatic logic [VALUE_W-1:0] bisector_to(logic [127:0] x, logic [127:0] y,
                                                     logic [127:0] z);
    logic [127:0] radicand;
    radicand = y * z * (x + y + z) * (y + z - x);
    return VALUE_W'(int_sqrt(radicand) / (y + z));
  endfunction

  function automatic void push_metric(int k, logic [VALUE_W-1:0] v, status_t st, logic lst);
    rsp_t r;
    r.quantity = qty_t'(k);
    r.value = v;
    r.status = st;
    r.last = lst;
    metric_q.push_back(r);
  endfunction

  // expected results of one triple, exact integer math on raw Q15.8 units
  function automatic void predict_metrics(req_t t);
    longint a, b, c;
    logic [127:0] ua, ub, uc, per, root;
    logic [VALUE_W-1:0] vals[12];
    a = longint'(t.side_a);
    b = longint'(t.side_b);
    c = longint'(t.side_c);
    if (a <= 0 || b <= 0 || c <= 0) begin
      push_metric(Q_PERIM, '0, ST_NONPOS, 1'b1);
      rejects++;
      return;
    end
    if (!(a + b > c && a + c > b && b + c > a)) begin
      push_metric(Q_PERIM, '0, ST_NOTRI, 1'b1);
      rejects++;
      return;
    end
    valid_triangles++;
    ua = a;
    ub = b;
    uc = c;
    per = ua + ub + uc;
    root = int_sqrt(per * (ub + uc - ua) * (ua + uc - ub) * (ua + ub - uc));
    vals[0] = VALUE_W'(per);
    vals[1] = VALUE_W'(per >> 1);
    vals[2] = VALUE_W'(root >> (FRAC + 2));
    vals[3] = VALUE_W'(root / (2 * ua));
    vals[4] = VALUE_W'(root / (2 * ub));
    vals[5] = VALUE_W'(root / (2 * uc));
    vals[6] = median_to(ua, ub, uc);
    vals[7] = median_to(ub, ua, uc);
    vals[8] = median_to(uc, ua, ub);
    vals[9] = bisector_to(ua, ub, uc);
    vals[10] = bisector_to(ub, ua, uc);
    vals[11] = bisector_to(uc, ua, ub);
    for (int k = 0; k < 12; k++) push_metric(k, vals[k], ST_OK, k == 11);
  endfunction

  // sender: bursts of random length, most of them separated by random gaps
  task automatic send_triple(int sa, int sb, int sc);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 30);
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req <= '{side_a: sa[23:0], side_b: sb[23:0], side_c: sc[23:0]};
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predict_metrics('{side_a: sa[23:0], side_b: sb[23:0], side_c: sc[23:0]});
    items_sent++;
  endtask

  task automatic send_triangle(int limit);
    int a, b, c, lo, hi;
    a = $urandom_range(1, limit);
    b = $urandom_range(1, limit);
    lo = (a > b ? a - b : b - a) + 1;
    hi = a + b - 1;
    if (hi > SIDE_MAX) hi = SIDE_MAX;
    c = $urandom_range(lo, hi);
    case ($urandom_range(0, 2))
      0: send_triple(a, b, c);
      1: send_triple(c, a, b);
      default: send_triple(b, c, a);
    endcase
  endtask

  task automatic test_directed();
    send_triple(256, 256, 256);
    send_triple(1, 1, 1);
    send_triple(SIDE_MAX, SIDE_MAX, SIDE_MAX);
    send_triple(SIDE_MAX, SIDE_MAX, 1);
    send_triple(3 << 8, 4 << 8, 5 << 8);
    send_triple(5 << 8, 3 << 8, 4 << 8);
    send_triple(0, 256, 256);
    send_triple(256, 0, 256);
    send_triple(256, 256, 0);
    send_triple(-1, 256, 256);
    send_triple(256, -8388608, 256);
    send_triple(256, 256, -8388608);
    send_triple(-8388608, -8388608, -8388608);
    send_triple(0, -5, 0);
    send_triple(1, 2, 3);
    send_triple(2, 1, 3);
    send_triple(3, 1, 2);
    send_triple(100, 1, 1);
    send_triple(SIDE_MAX, 1, 1);
    send_triple(SIDE_MAX, SIDE_MAX - 1, 1);
    send_triple(2, 2, 3);
    send_triple(1, SIDE_MAX, SIDE_MAX);
  endtask

  task automatic test_random_triples();
    int a, b, kind;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        send_triangle((kind == 0) ? SIDE_MAX : (1 << $urandom_range(1, 22)));
      end else if (kind == 8) begin
        send_triple($urandom, $urandom, $urandom);
      end else begin
        a = $urandom_range(1, 4194303);
        b = $urandom_range(1, 4194303);
        case ($urandom_range(0, 2))
          0: send_triple(a, b, a + b);
          1: send_triple(a + b + $urandom_range(0, 1000), a, b);
          default: send_triple(a, -$urandom_range(0, 8388608), b);
        endcase
      end
    end
    req_valid <= 1'b0;
  endtask

  // receiver: stall pattern alternates between quiet stretches and busy ones
  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (metric_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", rsp);
        end else begin
          rsp_t want;
          want = metric_q.pop_front();
          if (rsp.quantity !== want.quantity || rsp.value !== want.value ||
              rsp.status !== want.status || rsp.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected q=%0d v=%0d s=%0d l=%0d, got q=%0d v=%0d s=%0d l=%0d",
                       want.quantity, want.value, want.status, want.last,
                       rsp.quantity, rsp.value, rsp.status, rsp.last);
          end
        end
      end
      if ((cycle_count / 3000) % 3 == 0) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("** triangle_metrics_from_sides_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    req <= '0;
    req_valid <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_triples();
    while (metric_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d triples (%0d triangles, %0d rejected), checked %0d results",
             items_sent, valid_triangles, rejects, results_seen);
    if (mismatches == 0 && metric_q.size() == 0) begin
      $display("** triangle_metrics_from_sides_unit: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** triangle_metrics_from_sides_unit: FAILED **");
    end
    $finish;
  end

endmodule

[triangle_metrics_from_sides_unit.f]
src/tmfs_pkg.sv
src/tmfs_front.sv
src/tmfs_queue.sv
src/tmfs_back.sv
src/triangle_metrics_from_sides_unit.sv
test/triangle_metrics_from_sides_unit_test.sv
